// ===== src/prr_pkg.sv =====
// Shared types and constants of the packet reorder receiver.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package prr_pkg;

  localparam int SEQ_W      = 32;
  localparam int LEN_W      = 12;
  localparam int HANDLE_W   = 16;
  localparam int SLOT_OUT_W = 4;
  localparam int CFG_IDX_W  = 1;

  typedef enum logic [1:0] {
    KIND_DELIVER = 2'd0,
    KIND_STORE   = 2'd1,
    KIND_DRAIN   = 2'd2,
    KIND_ACK     = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAGIC     = 1'b0,
    REG_FIRST_SEQ = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [SEQ_W-1:0]    magic;
    logic [SEQ_W-1:0]    seq_number;
    logic [LEN_W-1:0]    payload_length;
    logic                end_of_file;
    logic [HANDLE_W-1:0] payload_handle;
  } in_item_t;

  typedef struct packed {
    kind_t                 kind;
    logic [SLOT_OUT_W-1:0] slot;
    logic [HANDLE_W-1:0]   out_handle;
    logic [LEN_W-1:0]      out_length;
    logic [SEQ_W-1:0]      ack_number;
    logic                  ack_eof;
    logic                  last;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic  capture;
    logic  classify;
    logic  emit;
    kind_t emit_kind;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic mod_busy;
    logic drop;
    logic in_order;
    logic in_win;
    logic slot_full;
    logic drain_ok;
    logic out_free;
  } dp_status_t;

endpackage

// ===== src/packet_reorder_receiver_unit.sv =====
// Top level of the packet reorder receiver.
// Depends on prr_pkg, prr_ctrl and prr_datapath.
`timescale 1ns / 1ps

// Receive-side reorder buffer: one packet descriptor per input item, zero or
// more result items out (deliver, store, drained slot, then a cumulative ack
// flagged last). Items are handled one at a time by a controller stepping a
// shared datapath. A dropped packet (wrong magic, or after an eof ack) emits
// nothing; an out-of-window or refused packet an ack; a stored packet a store
// and an ack; an in-order packet a deliver, a peek and drain per drained slot,
// then an ack, the drain reading the slot memory through its single registered
// read port. A stalled output holds the emitting state. Writing first_sequence
// starts a remainder computation of the slot pointer, during which no item is taken.

module packet_reorder_receiver_unit #(
  parameter int WINDOW      = 16,
  parameter int MAX_PAYLOAD = 2048
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  prr_pkg::in_item_t             in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output prr_pkg::out_item_t            out_item,
  input  logic                          cfg_we,
  input  logic [prr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [prr_pkg::SEQ_W-1:0]     cfg_data
);
  import prr_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  prr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  prr_datapath #(
    .WINDOW      (WINDOW),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

// ===== src/prr_datapath.sv =====
// Datapath of the packet reorder receiver: config registers, sequence
// tracking, window slot memory, slot index remainder unit, output register.
// Depends on prr_pkg.
`timescale 1ns / 1ps

module prr_datapath #(
  parameter int WINDOW      = 16,
  parameter int MAX_PAYLOAD = 2048
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  prr_pkg::ctrl_cmd_t                   cmd,
  output prr_pkg::dp_status_t                  status,
  input  prr_pkg::in_item_t                    in_item,
  input  logic                                 cfg_we,
  input  logic [prr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [prr_pkg::SEQ_W-1:0]            cfg_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output prr_pkg::out_item_t                   out_item
);
  import prr_pkg::*;

  localparam int SLOT_W = $clog2(WINDOW);
  localparam int MEM_W  = HANDLE_W + LEN_W;
  localparam int MAXP_W = 17;
  localparam logic [MAXP_W-1:0] MAX_P = MAXP_W'(MAX_PAYLOAD);
  localparam logic [SLOT_W:0]   WIN_X = (SLOT_W + 1)'(WINDOW);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

  // remainder unit: per-bit residue sum, then a reciprocal multiply for the
  // quotient of that sum; the sum stays below SEQ_W * WINDOW
  localparam int QUO_W  = $clog2(SEQ_W);
  localparam int ACC_W  = SLOT_W + QUO_W;
  localparam int RCP_SH = ACC_W + SLOT_W;
  localparam logic [RCP_SH-1:0] RCP_M = RCP_SH'((2 ** RCP_SH + WINDOW - 1) / WINDOW);
  localparam logic [ACC_W-1:0]  WIN_A = ACC_W'(WINDOW);
  localparam int MCNT_W = 2;

  logic [SEQ_W-1:0]  magic_reg;
  logic [SEQ_W-1:0]  exp_seq;
  logic [SLOT_W-1:0] exp_slot;
  logic [SLOT_W-1:0] st_slot;
  logic [SLOT_W-1:0] visited;
  logic              done;
  logic [WINDOW-1:0] slot_valid;
  in_item_t          item;
  in_item_t          item_next;
  logic              drop, in_order, in_win;

  logic [MEM_W-1:0]  mem [WINDOW];
  logic [MEM_W-1:0]  mem_rd;

  logic [ACC_W-1:0]  mod_acc;
  logic [QUO_W-1:0]  mod_quo;
  logic [MCNT_W-1:0] mod_cnt;

  logic [SEQ_W-1:0]  seq_dist;
  logic [SLOT_W:0]   slot_sum;
  logic [SLOT_W:0]   slot_red;
  logic [MAXP_W-1:0] len_ext;
  logic [LEN_W-1:0]  len_sat;
  logic [SLOT_W-1:0] exp_slot_inc;
  logic [ACC_W+RCP_SH-1:0] mod_prod;
  logic [ACC_W-1:0]  mod_qw;
  logic [ACC_W-1:0]  mod_diff;
  logic              store_wr;
  out_item_t         out_next;
  logic [SLOT_W+SLOT_OUT_W-1:0] st_slot_ext, exp_slot_ext;

  function automatic logic [ACC_W-1:0] residue_sum(logic [SEQ_W-1:0] v);
    logic [ACC_W-1:0] acc;
    int               wt;
    acc = '0;
    wt  = 1;
    for (int i = 0; i < SEQ_W; i++) begin
      if (v[i]) begin
        acc = acc + ACC_W'(wt);
      end
      // wt tracks 2**i mod WINDOW
      wt = (2 * wt >= WINDOW) ? 2 * wt - WINDOW : 2 * wt;
    end
    return acc;
  endfunction

  // window distance and target slot: (exp_slot + seq_dist) mod WINDOW, seq_dist < WINDOW
  assign seq_dist = item.seq_number - exp_seq;
  assign slot_sum = {1'b0, exp_slot} + {1'b0, seq_dist[SLOT_W-1:0]};
  assign slot_red = (slot_sum >= WIN_X) ? slot_sum - WIN_X : slot_sum;

  assign len_ext = MAXP_W'(in_item.payload_length);
  assign len_sat = (len_ext > MAX_P) ? MAX_P[LEN_W-1:0] : in_item.payload_length;

  always_comb begin
    item_next = in_item;
    item_next.payload_length = len_sat;
  end

  assign exp_slot_inc = (exp_slot == LAST_SLOT) ? '0 : exp_slot + SLOT_W'(1);

  assign mod_prod = {RCP_SH'(0), mod_acc} * {ACC_W'(0), RCP_M};
  assign mod_qw   = ACC_W'(mod_quo) * WIN_A;
  assign mod_diff = mod_acc - mod_qw;

  assign store_wr = cmd.emit && (cmd.emit_kind == KIND_STORE) && (item.payload_length != '0);

  assign st_slot_ext  = {SLOT_OUT_W'(0), st_slot};
  assign exp_slot_ext = {SLOT_OUT_W'(0), exp_slot};

  always_comb begin
    out_next = '0;
    out_next.kind = cmd.emit_kind;
    case (cmd.emit_kind)
      KIND_DELIVER: begin
        out_next.out_handle = item.payload_handle;
        out_next.out_length = item.payload_length;
      end
      KIND_STORE: begin
        out_next.slot       = st_slot_ext[SLOT_OUT_W-1:0];
        out_next.out_handle = item.payload_handle;
        out_next.out_length = item.payload_length;
      end
      KIND_DRAIN: begin
        out_next.slot       = exp_slot_ext[SLOT_OUT_W-1:0];
        out_next.out_handle = mem_rd[MEM_W-1:LEN_W];
        out_next.out_length = mem_rd[LEN_W-1:0];
      end
      default: begin
        out_next.ack_number = exp_seq;
        out_next.ack_eof    = item.end_of_file;
        out_next.last       = 1'b1;
      end
    endcase
  end

  always_comb begin
    status           = '0;
    status.mod_busy  = (mod_cnt != '0);
    status.drop      = drop;
    status.in_order  = in_order;
    status.in_win    = in_win;
    status.slot_full = slot_valid[st_slot];
    status.drain_ok  = slot_valid[exp_slot] && (visited != LAST_SLOT);
    status.out_free  = !out_valid || out_ready;
  end

  // item capture and classification
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= item_next;
    end
    if (cmd.classify) begin
      drop     <= done || (item.magic != magic_reg);
      in_order <= (seq_dist == '0);
      in_win   <= (seq_dist < SEQ_W'(WINDOW));
      st_slot  <= slot_red[SLOT_W-1:0];
    end
  end

  // slot memory; read port follows the drain pointer
  always_ff @(posedge clk) begin
    if (store_wr) begin
      mem[st_slot] <= {item.payload_handle, item.payload_length};
    end
    mem_rd <= mem[exp_slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      magic_reg  <= '0;
      exp_seq    <= SEQ_W'(1);
      exp_slot   <= SLOT_W'(1);
      done       <= 1'b0;
      slot_valid <= '0;
      visited    <= '0;
      mod_acc    <= '0;
      mod_quo    <= '0;
      mod_cnt    <= '0;
    end else begin
      if (cmd.emit) begin
        case (cmd.emit_kind)
          KIND_DELIVER: begin
            exp_seq  <= exp_seq + SEQ_W'(1);
            exp_slot <= exp_slot_inc;
            visited  <= '0;
          end
          KIND_STORE: begin
            if (store_wr) begin
              slot_valid[st_slot] <= 1'b1;
            end
          end
          KIND_DRAIN: begin
            slot_valid[exp_slot] <= 1'b0;
            exp_seq  <= exp_seq + SEQ_W'(1);
            exp_slot <= exp_slot_inc;
            visited  <= visited + SLOT_W'(1);
          end
          default: begin
            if (item.end_of_file) begin
              done <= 1'b1;
            end
          end
        endcase
      end
      if (mod_cnt != '0) begin
        mod_cnt <= mod_cnt - MCNT_W'(1);
        if (mod_cnt == MCNT_W'(2)) begin
          mod_quo <= mod_prod[RCP_SH +: QUO_W];
        end else begin
          exp_slot <= mod_diff[SLOT_W-1:0];
        end
      end
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_MAGIC: begin
            magic_reg <= cfg_data;
          end
          REG_FIRST_SEQ: begin
            exp_seq <= cfg_data;
            mod_acc <= residue_sum(cfg_data);
            mod_cnt <= MCNT_W'(2);
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_item <= out_next;
    end
  end

endmodule

// ===== src/prr_ctrl.sv =====
// Controller of the packet reorder receiver: sequences classify, deliver,
// store, drain and ack for one packet at a time. Depends on prr_pkg.
`timescale 1ns / 1ps

module prr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  prr_pkg::dp_status_t status,
  output prr_pkg::ctrl_cmd_t  cmd
);
  import prr_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_CLASS   = 8'b0000_0010,
    S_DECIDE  = 8'b0000_0100,
    S_DELIVER = 8'b0000_1000,
    S_STORE   = 8'b0001_0000,
    S_PEEK    = 8'b0010_0000,
    S_DRAIN   = 8'b0100_0000,
    S_ACK     = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next  = state;
    cmd         = '0;
    in_ready    = (state == S_IDLE) && !status.mod_busy;
    cmd.capture = in_valid && in_ready;
    unique case (state)
      S_IDLE: begin
        if (cmd.capture) begin
          state_next = S_CLASS;
        end
      end
      S_CLASS: begin
        cmd.classify = 1'b1;
        state_next   = S_DECIDE;
      end
      S_DECIDE: begin
        if (status.drop) begin
          state_next = S_IDLE;
        end else if (status.in_order) begin
          state_next = S_DELIVER;
        end else if (status.in_win && !status.slot_full) begin
          state_next = S_STORE;
        end else begin
          state_next = S_ACK;
        end
      end
      S_DELIVER: begin
        cmd.emit_kind = KIND_DELIVER;
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_PEEK;
        end
      end
      S_STORE: begin
        cmd.emit_kind = KIND_STORE;
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_ACK;
        end
      end
      // slot memory read of the next slot is in flight here
      S_PEEK: begin
        state_next = status.drain_ok ? S_DRAIN : S_ACK;
      end
      S_DRAIN: begin
        cmd.emit_kind = KIND_DRAIN;
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_PEEK;
        end
      end
      S_ACK: begin
        cmd.emit_kind = KIND_ACK;
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== src/prr_checker.sv =====
// Port-level checks of the packet reorder receiver, bound to the top level.
// Depends on prr_pkg and packet_reorder_receiver_unit.
`timescale 1ns / 1ps

module prr_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input prr_pkg::out_item_t out_item
);
  import prr_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result item changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result item valid right after reset");

  a_ack_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.kind == KIND_ACK) |->
      out_item.last && (out_item.slot == '0) && (out_item.out_handle == '0) &&
      (out_item.out_length == '0))
    else $error("ack item malformed");

  a_data_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.kind != KIND_ACK) |->
      !out_item.last && !out_item.ack_eof && (out_item.ack_number == '0))
    else $error("non-ack item carries ack fields");

  // an ack always follows a non-ack item, so no new packet may be taken yet
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.kind != KIND_ACK) |-> !in_ready)
    else $error("new item taken before ack of previous one");

endmodule

bind packet_reorder_receiver_unit prr_checker u_prr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
